// ===== design/assert_macros.svh =====
// assertion macros shared by the spiral order reader rtl
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, held off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/sor_pkg.sv =====
// shared types, constants and helpers for the spiral order reader
// no dependencies
package sor_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int DIM_W      = 5;
	localparam int IDX_W      = 4;
	localparam int ADDR_W     = 8;
	localparam int DEPTH      = 256;
	localparam int CNT_W      = 9;
	localparam int BND_W      = 6;
	localparam int CFG_IDX_W  = 1;

	localparam logic [DIM_W-1:0] ROWS_MAX = 5'd16;
	localparam logic [DIM_W-1:0] COLS_MAX = 5'd16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd1;

	// item actions
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EMIT = 1'b1;

	// walk directions
	localparam logic [1:0] DIR_RIGHT = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_UP    = 2'd3;

	typedef logic signed [BND_W-1:0] bnd_t;

	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [DIM_W-1:0]     data;
	} cfg_wr_t;

	typedef struct packed {
		logic [ADDR_W-1:0] wr_addr;
		logic [ADDR_W-1:0] rd_addr;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic              last;
	} walk_t;

	// zero acts as one, large values clamp to the maximum
	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] vmax);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > vmax) begin
			r = vmax;
		end
		return r;
	endfunction

endpackage

// ===== design/sor_item_if.sv =====
// input channel of the spiral order reader: action and element value
// depends on sor_pkg
interface sor_item_if import sor_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic signed [DATA_WIDTH-1:0] value;

	modport source(output valid, output action, output value, input ready);
	modport sink(input valid, input action, input value, output ready);
endinterface

// ===== design/sor_result_if.sv =====
// result channel of the spiral order reader: element, position, last flag
// depends on sor_pkg
interface sor_result_if import sor_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] data_out;
	logic [IDX_W-1:0]             row_index;
	logic [IDX_W-1:0]             col_index;
	logic                         last;

	modport source(output valid, output data_out, output row_index, output col_index,
		output last, input ready);
	modport sink(input valid, input data_out, input row_index, input col_index,
		input last, output ready);
endinterface

// ===== design/sor_ram.sv =====
// generic single write port, single read port memory with registered read
// no dependencies
module sor_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, holds when idle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ===== design/sor_walk.sv =====
// spiral walk state: dimensions, bounds, position, count and load pointer
// depends on sor_pkg
module sor_walk import sor_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_wr_t cfg,
	input  logic    load_en,
	input  logic    emit_en,
	output walk_t   walk
);
	logic [DIM_W-1:0]  rows_q, cols_q, n_rows, n_cols;
	logic [ADDR_W-1:0] lp_q, n_lp;
	bnd_t              top_q, bottom_q, left_q, right_q;
	bnd_t              n_top, n_bottom, n_left, n_right;
	logic [IDX_W-1:0]  row_q, col_q, n_row, n_col;
	logic [1:0]        dir_q, n_dir;
	logic [CNT_W-1:0]  cnt_q, n_cnt, cnt_inc, total;
	logic [CNT_W-1:0]  wa_full, wa_inc, rd_full;
	logic              rearm, shrink, fin;
	bnd_t              row_s, col_s;

	// derived values from the current state
	always_comb begin
		total   = CNT_W'(rows_q) * CNT_W'(cols_q);
		wa_full = (CNT_W'(lp_q) >= total) ? '0 : CNT_W'(lp_q);
		wa_inc  = wa_full + CNT_W'(1);
		rd_full = CNT_W'(row_q) * CNT_W'(cols_q) + CNT_W'(col_q);
		cnt_inc = cnt_q + CNT_W'(1);
		fin     = (cnt_inc >= total);
		row_s   = $signed({2'b00, row_q});
		col_s   = $signed({2'b00, col_q});
	end

	assign walk.wr_addr = wa_full[ADDR_W-1:0];
	assign walk.rd_addr = rd_full[ADDR_W-1:0];
	assign walk.row     = row_q;
	assign walk.col     = col_q;
	assign walk.last    = fin;

	// next state
	always_comb begin
		n_rows   = rows_q;
		n_cols   = cols_q;
		n_lp     = lp_q;
		n_top    = top_q;
		n_bottom = bottom_q;
		n_left   = left_q;
		n_right  = right_q;
		n_row    = row_q;
		n_col    = col_q;
		n_dir    = dir_q;
		n_cnt    = cnt_q;
		rearm    = 1'b0;
		shrink   = 1'b0;
		if (cfg.we) begin
			case (cfg.index)
				REG_NUM_ROWS: begin
					n_rows = sat_dim(cfg.data, ROWS_MAX);
					rearm  = 1'b1;
				end
				REG_NUM_COLS: begin
					n_cols = sat_dim(cfg.data, COLS_MAX);
					rearm  = 1'b1;
				end
				default: begin
					rearm = 1'b0;
				end
			endcase
		end else if (load_en) begin
			n_lp = (wa_inc >= total) ? '0 : wa_inc[ADDR_W-1:0];
		end else if (emit_en) begin
			if (fin) begin
				rearm = 1'b1;
			end else begin
				n_cnt = cnt_inc;
				// step along the current edge or shrink the finished side
				case (dir_q)
					DIR_RIGHT: begin
						if (col_s < right_q) n_col = col_q + IDX_W'(1);
						else begin n_top = top_q + BND_W'(1); shrink = 1'b1; end
					end
					DIR_DOWN: begin
						if (row_s < bottom_q) n_row = row_q + IDX_W'(1);
						else begin n_right = right_q - BND_W'(1); shrink = 1'b1; end
					end
					DIR_LEFT: begin
						if (col_s > left_q) n_col = col_q - IDX_W'(1);
						else begin n_bottom = bottom_q - BND_W'(1); shrink = 1'b1; end
					end
					default: begin
						if (row_s > top_q) n_row = row_q - IDX_W'(1);
						else begin n_left = left_q + BND_W'(1); shrink = 1'b1; end
					end
				endcase
				// turn the corner onto the next edge
				if (shrink) begin
					n_dir = dir_q + 2'd1;
					if (!(n_top > n_bottom || n_left > n_right)) begin
						case (n_dir)
							DIR_RIGHT: begin
								n_row = n_top[IDX_W-1:0];
								n_col = n_left[IDX_W-1:0];
							end
							DIR_DOWN: begin
								n_row = n_top[IDX_W-1:0];
								n_col = n_right[IDX_W-1:0];
							end
							DIR_LEFT: begin
								n_row = n_bottom[IDX_W-1:0];
								n_col = n_right[IDX_W-1:0];
							end
							default: begin
								n_row = n_bottom[IDX_W-1:0];
								n_col = n_left[IDX_W-1:0];
							end
						endcase
					end
				end
			end
		end
		// rearm load pointer and walk for the (possibly new) dimensions
		if (rearm) begin
			n_lp     = '0;
			n_top    = '0;
			n_bottom = $signed({1'b0, n_rows}) - BND_W'(1);
			n_left   = '0;
			n_right  = $signed({1'b0, n_cols}) - BND_W'(1);
			n_row    = '0;
			n_col    = '0;
			n_dir    = DIR_RIGHT;
			n_cnt    = '0;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= ROWS_MAX;
			cols_q   <= COLS_MAX;
			lp_q     <= '0;
			top_q    <= '0;
			bottom_q <= $signed({1'b0, ROWS_MAX}) - BND_W'(1);
			left_q   <= '0;
			right_q  <= $signed({1'b0, COLS_MAX}) - BND_W'(1);
			row_q    <= '0;
			col_q    <= '0;
			dir_q    <= DIR_RIGHT;
			cnt_q    <= '0;
		end else begin
			rows_q   <= n_rows;
			cols_q   <= n_cols;
			lp_q     <= n_lp;
			top_q    <= n_top;
			bottom_q <= n_bottom;
			left_q   <= n_left;
			right_q  <= n_right;
			row_q    <= n_row;
			col_q    <= n_col;
			dir_q    <= n_dir;
			cnt_q    <= n_cnt;
		end
	end
endmodule

// ===== design/spiral_order_reader_unit.sv =====
// spiral order reader top level: walk state, element store, result pipeline
// depends on sor_pkg, sor_item_if, sor_result_if, sor_ram, sor_walk, assert_macros.svh
//
//   channel   direction  payload                                 per transaction
//   items     sink       action, value                           load or emit request
//   results   source     data_out, row_index, col_index, last    one spiral element
//   cfg       write      cfg_wr_en, cfg_index, cfg_data          num_rows / num_cols
//
// one item per cycle while ready is high; a load is done at acceptance, an emit is read
// into the store read register, then into the output register once that may advance
// the store read port and the output register form a two-entry pipeline, so an
// item is taken while one result waits; ready drops only when both are full
// reset rearms the walk with 16 x 16; store contents are undefined until loaded
`include "assert_macros.svh"

module spiral_order_reader_unit import sor_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	sor_item_if.sink             items,
	sor_result_if.source         results,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);
	cfg_wr_t                 cfg;
	walk_t                   walk;
	logic                    item_acc, load_en, emit_en, s1_adv;
	logic                    valid_s1, last_s1;
	logic [IDX_W-1:0]        row_s1, col_s1;
	logic [DATA_WIDTH-1:0]   rd_data_s1;
	logic                    out_valid_q, last_q;
	logic [IDX_W-1:0]        row_q, col_q;
	logic [DATA_WIDTH-1:0]   data_q;

	// handshake and item decode
	assign s1_adv       = !out_valid_q || results.ready;
	assign items.ready  = !valid_s1 || s1_adv;
	assign item_acc     = items.valid && items.ready;
	assign load_en      = item_acc && (items.action == ACT_LOAD);
	assign emit_en      = item_acc && (items.action == ACT_EMIT);

	assign cfg.we    = cfg_wr_en;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	sor_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.load_en (load_en),
		.emit_en (emit_en),
		.walk    (walk)
	);

	sor_ram #(
		.DEPTH (DEPTH),
		.WIDTH (DATA_WIDTH)
	) u_store (
		.clk     (clk),
		.wr_en   (load_en),
		.wr_addr (walk.wr_addr),
		.wr_data (items.value),
		.rd_en   (emit_en),
		.rd_addr (walk.rd_addr),
		.rd_data (rd_data_s1)
	);

	// stage 1 control alongside the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (emit_en) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			row_s1  <= walk.row;
			col_s1  <= walk.col;
			last_s1 <= walk.last;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			data_q <= rd_data_s1;
			row_q  <= row_s1;
			col_q  <= col_s1;
			last_q <= last_s1;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.data_out  = $signed(data_q);
	assign results.row_index = row_q;
	assign results.col_index = col_q;
	assign results.last      = last_q;

	// checks
	`ASSERT_NEXT(a_emit_fills_s1, clk, arst_n, emit_en, valid_s1)
	`ASSERT_IMPL(a_stall_only_when_full, clk, arst_n, !items.ready,
		valid_s1 && out_valid_q)
	`ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !s1_adv,
		valid_s1 && $stable(rd_data_s1) && $stable(row_s1) && $stable(col_s1))
endmodule

// ===== test/tb_spiral_order_reader_unit.sv =====
// self-checking testbench for spiral_order_reader_unit: table-driven directed items,
// then random matrix shapes with load/emit sequences checked against a shadow walk
// depends on sor_pkg, sor_item_if, sor_result_if and the design under test
`timescale 1ns / 1ps

module tb_spiral_order_reader_unit;
	import sor_pkg::*;

	localparam int ITEM_TARGET  = 1600;
	localparam int CYCLE_LIMIT  = 700000;
	localparam int MAX_GAP      = 19;
	localparam int DRAIN_CYCLES = 4;
	localparam int N_DIRECTED   = 21;
	localparam int N_FIXED      = 8;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] data;
		logic [IDX_W-1:0]      row;
		logic [IDX_W-1:0]      col;
		logic                  last;
	} elem_t;

	typedef struct {
		logic                         act;
		logic signed [DATA_WIDTH-1:0] val;
		bit                           typed;
		elem_t                        want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;

	sor_item_if   items_ch();
	sor_result_if results_ch();

	spiral_order_reader_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items_ch),
		.results   (results_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow copy of the block state
	logic [DATA_WIDTH-1:0] shadow_mem [DEPTH];
	bit                    shadow_loaded [DEPTH];
	logic [DIM_W-1:0]      rows_reg;
	logic [DIM_W-1:0]      cols_reg;
	int unsigned           load_ptr;
	int                    top_b;
	int                    bot_b;
	int                    left_b;
	int                    right_b;
	int                    cur_row;
	int                    cur_col;
	logic [1:0]            walk_dir;
	int unsigned           emit_cnt;

	elem_t       pending_elems [$];
	int          n_fail;
	int          n_loads;
	int          n_emits;
	int          n_checked;
	int          n_spirals;
	int          n_cfg;
	int          n_shapes;
	bit          no_idle;
	int unsigned cycle_cnt;

	// directed items: 2 x 3 matrix with extreme values, emit before load, load wrap
	stim_row_t stim_table [N_DIRECTED] = '{
		'{ACT_LOAD, 32'sh8000_0000, 1'b0, '0},
		'{ACT_LOAD, 32'sh7FFF_FFFF, 1'b0, '0},
		'{ACT_LOAD, 32'sh0000_0000, 1'b0, '0},
		'{ACT_LOAD, 32'shFFFF_FFFF, 1'b0, '0},
		'{ACT_LOAD, 32'sh5555_5555, 1'b0, '0},
		'{ACT_LOAD, 32'shAAAA_AAAA, 1'b0, '0},
		'{ACT_EMIT, 32'sh0000_0000, 1'b1, '{32'h8000_0000, 4'd0, 4'd0, 1'b0}},
		'{ACT_EMIT, 32'shFFFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 4'd0, 4'd1, 1'b0}},
		'{ACT_EMIT, 32'sh0000_0000, 1'b1, '{32'h0000_0000, 4'd0, 4'd2, 1'b0}},
		'{ACT_EMIT, 32'sh1234_5678, 1'b1, '{32'hAAAA_AAAA, 4'd1, 4'd2, 1'b0}},
		'{ACT_EMIT, 32'sh0000_0000, 1'b1, '{32'h5555_5555, 4'd1, 4'd1, 1'b0}},
		'{ACT_EMIT, 32'sh0000_0000, 1'b1, '{32'hFFFF_FFFF, 4'd1, 4'd0, 1'b1}},
		'{ACT_EMIT, 32'sh0000_0000, 1'b0, '0},
		'{ACT_LOAD, 32'sh0000_0001, 1'b0, '0},
		'{ACT_LOAD, 32'sh0000_0002, 1'b0, '0},
		'{ACT_LOAD, 32'sh0000_0003, 1'b0, '0},
		'{ACT_LOAD, 32'sh0000_0004, 1'b0, '0},
		'{ACT_LOAD, 32'sh0000_0005, 1'b0, '0},
		'{ACT_LOAD, 32'sh0000_0006, 1'b0, '0},
		'{ACT_LOAD, 32'sh0000_0007, 1'b0, '0},
		'{ACT_EMIT, 32'sh0000_0000, 1'b0, '0}
	};

	// fixed shapes first: single element, single row, single column, zero, saturation
	logic [DIM_W-1:0] fixed_rows [N_FIXED] = '{5'd1, 5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd17, 5'd0};
	logic [DIM_W-1:0] fixed_cols [N_FIXED] = '{5'd1, 5'd16, 5'd1, 5'd5, 5'd17, 5'd4, 5'd0, 5'd0};

	// zero acts as one, values above the maximum clamp
	function automatic int eff_dim(input logic [DIM_W-1:0] v, input logic [DIM_W-1:0] vmax);
		if (v == '0) begin
			return 1;
		end
		if (v > vmax) begin
			return int'(vmax);
		end
		return int'(v);
	endfunction

	function automatic void rearm_walk();
		load_ptr = 0;
		top_b    = 0;
		bot_b    = eff_dim(rows_reg, ROWS_MAX) - 1;
		left_b   = 0;
		right_b  = eff_dim(cols_reg, COLS_MAX) - 1;
		cur_row  = 0;
		cur_col  = 0;
		walk_dir = DIR_RIGHT;
		emit_cnt = 0;
	endfunction

	function automatic void shadow_config(input logic [CFG_IDX_W-1:0] idx,
			input logic [DIM_W-1:0] v);
		case (idx)
			REG_NUM_ROWS: rows_reg = v;
			REG_NUM_COLS: cols_reg = v;
			default: return;
		endcase
		rearm_walk();
	endfunction

	// store address the next emit reads; an out-of-range position restarts at the origin
	function automatic int next_emit_addr();
		int rows;
		int cols;
		int r;
		int c;
		rows = eff_dim(rows_reg, ROWS_MAX);
		cols = eff_dim(cols_reg, COLS_MAX);
		r = cur_row;
		c = cur_col;
		if (r < 0 || r >= rows || c < 0 || c >= cols) begin
			r = 0;
			c = 0;
		end
		return (r * cols + c) % DEPTH;
	endfunction

	// one accepted item: returns 1 and the element when an emit produces a result
	function automatic bit spiral_predict(input logic act,
			input logic signed [DATA_WIDTH-1:0] val, output elem_t res);
		int rows;
		int cols;
		int unsigned total;
		int addr;
		rows  = eff_dim(rows_reg, ROWS_MAX);
		cols  = eff_dim(cols_reg, COLS_MAX);
		total = rows * cols;
		res   = '0;
		if (act == ACT_LOAD) begin
			if (load_ptr >= total) begin
				load_ptr = 0;
			end
			shadow_mem[load_ptr % DEPTH]    = val;
			shadow_loaded[load_ptr % DEPTH] = 1'b1;
			load_ptr++;
			if (load_ptr >= total) begin
				load_ptr = 0;
			end
			return 1'b0;
		end
		if (cur_row < 0 || cur_row >= rows || cur_col < 0 || cur_col >= cols) begin
			rearm_walk();
		end
		addr = next_emit_addr();
		emit_cnt++;
		res.data = shadow_mem[addr];
		res.row  = IDX_W'(cur_row);
		res.col  = IDX_W'(cur_col);
		res.last = (emit_cnt >= total);
		if (res.last) begin
			rearm_walk();
			return 1'b1;
		end
		// step along the current side; at its end shrink one bound and turn
		case (walk_dir)
			DIR_RIGHT: begin
				if (cur_col < right_b) begin
					cur_col++;
					return 1'b1;
				end
				top_b++;
			end
			DIR_DOWN: begin
				if (cur_row < bot_b) begin
					cur_row++;
					return 1'b1;
				end
				right_b--;
			end
			DIR_LEFT: begin
				if (cur_col > left_b) begin
					cur_col--;
					return 1'b1;
				end
				bot_b--;
			end
			default: begin
				if (cur_row > top_b) begin
					cur_row--;
					return 1'b1;
				end
				left_b++;
			end
		endcase
		walk_dir = walk_dir + 2'd1;
		if (top_b > bot_b || left_b > right_b) begin
			return 1'b1;
		end
		case (walk_dir)
			DIR_RIGHT: begin
				cur_row = top_b;
				cur_col = left_b;
			end
			DIR_DOWN: begin
				cur_row = top_b;
				cur_col = right_b;
			end
			DIR_LEFT: begin
				cur_row = bot_b;
				cur_col = right_b;
			end
			default: begin
				cur_row = bot_b;
				cur_col = left_b;
			end
		endcase
		return 1'b1;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("spiral_order_reader_unit regression: fail");
			$finish;
		end
	end

	// one item transaction; an untyped emit that would read a never-loaded entry becomes a load
	task automatic send_item(input logic act, input logic signed [DATA_WIDTH-1:0] val,
			input bit typed, input elem_t want);
		int gap;
		logic a;
		elem_t got;
		elem_t expd;
		a = act;
		if (!typed && a == ACT_EMIT && !shadow_loaded[next_emit_addr()]) begin
			a = ACT_LOAD;
		end
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			items_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_ch.valid  <= 1'b1;
		items_ch.action <= a;
		items_ch.value  <= val;
		do @(posedge clk); while (!items_ch.ready);
		if (spiral_predict(a, val, got)) begin
			expd = typed ? want : got;
			pending_elems = {pending_elems, expd};
			n_emits++;
		end else begin
			n_loads++;
		end
	endtask

	// random element value, extremes now and then
	task automatic send_rand(input logic act);
		logic signed [DATA_WIDTH-1:0] v;
		case ($urandom_range(0, 11))
			0: v = 32'sh8000_0000;
			1: v = 32'sh7FFF_FFFF;
			2: v = '0;
			3: v = '1;
			default: v = $urandom();
		endcase
		send_item(act, v, 1'b0, '0);
	endtask

	// stop sending and wait until every expected element has come back
	task automatic drain_results();
		items_ch.valid <= 1'b0;
		while (pending_elems.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow_config(idx, v);
		n_cfg++;
	endtask

	task automatic set_shape(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c);
		drain_results();
		write_reg(REG_NUM_ROWS, r);
		write_reg(REG_NUM_COLS, c);
		n_shapes++;
	endtask

	// result side: random stalls, then compare against the oldest expectation
	initial begin
		int stall;
		elem_t want;
		results_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				results_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results_ch.ready <= 1'b1;
			do @(posedge clk); while (!results_ch.valid);
			if (pending_elems.size() == 0) begin
				$error("unexpected result transaction: data_out %0d row %0d col %0d last %0b",
					results_ch.data_out, results_ch.row_index, results_ch.col_index,
					results_ch.last);
				n_fail++;
			end else begin
				want = pending_elems.pop_front();
				n_checked++;
				if (results_ch.data_out !== want.data) begin
					$error("data_out: expected %0d, got %0d", $signed(want.data),
						results_ch.data_out);
					n_fail++;
				end
				if (results_ch.row_index !== want.row) begin
					$error("row_index: expected %0d, got %0d", want.row, results_ch.row_index);
					n_fail++;
				end
				if (results_ch.col_index !== want.col) begin
					$error("col_index: expected %0d, got %0d", want.col, results_ch.col_index);
					n_fail++;
				end
				if (results_ch.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, results_ch.last);
					n_fail++;
				end
				if (want.last) begin
					n_spirals++;
				end
			end
		end
	end

	// stimulus
	initial begin
		int phase;
		int reps;
		int unsigned total;
		logic [DIM_W-1:0] r;
		logic [DIM_W-1:0] c;
		arst_n          <= 1'b0;
		cfg_wr_en       <= 1'b0;
		cfg_index       <= REG_NUM_ROWS;
		cfg_data        <= '0;
		items_ch.valid  <= 1'b0;
		items_ch.action <= ACT_LOAD;
		items_ch.value  <= '0;
		no_idle   = 1'b0;
		n_fail    = 0;
		n_loads   = 0;
		n_emits   = 0;
		n_checked = 0;
		n_spirals = 0;
		n_cfg     = 0;
		n_shapes  = 0;
		rows_reg  = ROWS_MAX;
		cols_reg  = COLS_MAX;
		foreach (shadow_loaded[i]) begin
			shadow_loaded[i] = 1'b0;
			shadow_mem[i]    = '0;
		end
		rearm_walk();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		set_shape(5'd2, 5'd3);
		foreach (stim_table[i]) begin
			send_item(stim_table[i].act, stim_table[i].val, stim_table[i].typed,
				stim_table[i].want);
		end

		// random part: one shape per phase, mostly full load-then-emit passes
		phase = 0;
		while (n_loads + n_emits < N_DIRECTED + ITEM_TARGET) begin
			if (phase < N_FIXED) begin
				r = fixed_rows[phase];
				c = fixed_cols[phase];
			end else begin
				r = DIM_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) :
					$urandom_range(1, 6));
				c = DIM_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) :
					$urandom_range(1, 6));
			end
			set_shape(r, c);
			no_idle = ($urandom_range(0, 3) == 0);
			total = eff_dim(rows_reg, ROWS_MAX) * eff_dim(cols_reg, COLS_MAX);
			reps = (total > 64) ? 1 : $urandom_range(1, 3);
			repeat (reps) begin
				case ($urandom_range(0, 9))
					0, 1: begin
						repeat ($urandom_range(4, 24)) send_rand(1'($urandom_range(0, 1)));
					end
					2: begin
						repeat ($urandom_range(1, total)) send_rand(ACT_LOAD);
						repeat ($urandom_range(1, total)) send_rand(ACT_EMIT);
					end
					default: begin
						repeat (total) send_rand(ACT_LOAD);
						repeat (total) send_rand(ACT_EMIT);
					end
				endcase
				if ($urandom_range(0, 19) == 0) begin
					drain_results();
				end
			end
			phase++;
		end

		drain_results();
		repeat (8) @(posedge clk);
		$display("covered %0d shapes, %0d register writes, %0d loads, %0d emits",
			n_shapes, n_cfg, n_loads, n_emits);
		$display("checked %0d elements over %0d completed spirals, %0d mismatches",
			n_checked, n_spirals, n_fail);
		if (n_fail == 0) begin
			$display("spiral_order_reader_unit regression: pass");
		end else begin
			$display("spiral_order_reader_unit regression: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/sor_pkg.sv
design/sor_item_if.sv
design/sor_result_if.sv
design/sor_ram.sv
design/sor_walk.sv
design/spiral_order_reader_unit.sv
test/tb_spiral_order_reader_unit.sv
